// File: rtl/acs_pkg.sv
package acs_pkg;

    localparam int TABLE_DEPTH_DEF = 256;
    localparam int STEP_BITS_DEF   = 24;

    localparam int FUNC_W       = 2;
    localparam int IDX_W        = 8;
    localparam int ATT_W        = 16;
    localparam int ENTRY_STEP_W = 24;
    localparam int STATUS_W     = 2;
    localparam int MOVE_W       = 25;
    localparam int SPEED_W      = 9;
    localparam int POS_W        = 24;
    localparam int LEN_W        = 9;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    // Width of twice the widest segment span, which is the divisor of the interpolation.
    localparam int DEN_W = ATT_W + 1;

    localparam logic [LEN_W-1:0] LEN_RESET = 9'd2;
    localparam logic [LEN_W-1:0] LEN_MIN   = 9'd2;
    localparam logic [ATT_W-1:0] MIN_RESET = 16'd0;
    localparam logic [ATT_W-1:0] MAX_RESET = 16'hFFFF;

    localparam int RANGE_DEN = 1000;
    localparam int RANGE_HI  = 1001;
    localparam int RANGE_LO  = 999;

    localparam int OVERSHOOT = 50;
    localparam logic [SPEED_W-1:0] FAST_SPEED = 9'd300;
    localparam logic [SPEED_W-1:0] SLOW_SPEED = 9'd100;
    localparam logic [SPEED_W-1:0] NO_SPEED   = 9'd0;

    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_ATT      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATT      = 2'd2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD = 2'd0,
        FUNC_INIT = 2'd1,
        FUNC_MOVE = 2'd2
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_TOO_LARGE = 2'd1,
        ST_TOO_SMALL = 2'd2,
        ST_NO_INIT   = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SRCH,
        S_SRCH_CMP,
        S_RD_HI,
        S_CAP_HI,
        S_MUL_A,
        S_MUL_B,
        S_DIV_START,
        S_DIV_WAIT,
        S_END_CAP,
        S_FINISH,
        S_OUT1,
        S_OUT2,
        S_OUT3
    } state_t;

    typedef struct packed {
        logic done;
        logic ovf;
    } acs_div_stat_t;

endpackage

// File: rtl/acs_if.sv
interface acs_cmd_if;
    import acs_pkg::*;

    logic                           valid;
    logic                           ready;
    logic [FUNC_W-1:0]              func;
    logic [IDX_W-1:0]               entry_index;
    logic [ATT_W-1:0]               target_attenuation;
    logic signed [ENTRY_STEP_W-1:0] entry_step;

    modport source (
        output valid, func, entry_index, target_attenuation, entry_step,
        input  ready
    );

    modport sink (
        input  valid, func, entry_index, target_attenuation, entry_step,
        output ready
    );
endinterface

interface acs_res_if;
    import acs_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic signed [MOVE_W-1:0] move_steps;
    logic [SPEED_W-1:0]       move_speed;
    logic signed [POS_W-1:0]  position;
    logic                     last;

    modport source (
        output valid, status, move_steps, move_speed, position, last,
        input  ready
    );

    modport sink (
        input  valid, status, move_steps, move_speed, position, last,
        output ready
    );
endinterface

// File: rtl/acs_table.sv
module acs_table #(
    parameter int TABLE_DEPTH = acs_pkg::TABLE_DEPTH_DEF,
    parameter int STEP_BITS   = acs_pkg::STEP_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              we,
    input  logic [$clog2(TABLE_DEPTH)-1:0]    waddr,
    input  logic [acs_pkg::ATT_W-1:0]         watt,
    input  logic signed [STEP_BITS-1:0]       wstep,
    input  logic [$clog2(TABLE_DEPTH)-1:0]    raddr,
    output logic [acs_pkg::ATT_W-1:0]         ratt,
    output logic signed [STEP_BITS-1:0]       rstep
);
    import acs_pkg::*;

    logic [ATT_W-1:0]            att_mem  [TABLE_DEPTH];
    logic signed [STEP_BITS-1:0] step_mem [TABLE_DEPTH];
    logic [ATT_W-1:0]            rd_att_reg;
    logic signed [STEP_BITS-1:0] rd_step_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            att_mem[waddr]  <= watt;
            step_mem[waddr] <= wstep;
        end
        rd_att_reg  <= att_mem[raddr];
        rd_step_reg <= step_mem[raddr];
    end

    assign ratt  = rd_att_reg;
    assign rstep = rd_step_reg;

endmodule

// File: rtl/acs_div.sv
module acs_div #(
    parameter int STEP_BITS = acs_pkg::STEP_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [STEP_BITS+20:0]       num,
    input  logic [acs_pkg::DEN_W-1:0]   den,
    output logic [STEP_BITS-1:0]        quo,
    output acs_pkg::acs_div_stat_t      stat
);
    import acs_pkg::*;

    localparam int QW    = STEP_BITS;
    localparam int NUM_W = QW + 21;
    localparam int CW    = $clog2(QW);

    logic              busy_reg;
    logic              done_reg;
    logic              ovf_reg;
    logic [CW-1:0]     cnt_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [QW-1:0]     sh_reg;
    logic [DEN_W:0]    rem_try;
    logic [DEN_W:0]    rem_sub;
    logic              fits;
    logic              ovf_now;

    // Restoring division, one quotient bit per cycle. The quotient shifts
    // into the register that held the low numerator bits.
    assign rem_try = {rem_reg, sh_reg[QW-1]};
    assign fits    = rem_try >= {1'b0, den_reg};
    assign rem_sub = rem_try - {1'b0, den_reg};
    assign ovf_now = num >= NUM_W'({den, {QW{1'b0}}});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CW'(QW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num[QW +: DEN_W];
            sh_reg  <= num[QW-1:0];
            den_reg <= den;
            ovf_reg <= ovf_now;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? rem_sub[DEN_W-1:0] : rem_try[DEN_W-1:0];
            sh_reg  <= {sh_reg[QW-2:0], fits};
        end
    end

    assign quo       = sh_reg;
    assign stat.done = done_reg;
    assign stat.ovf  = ovf_reg;

endmodule

// File: rtl/attenuator_calibration_stepper.sv
// Load requests give no result; the block stays ready for the next request.
// Init and move requests pass the range check, search (S_SRCH, S_SRCH_CMP per halving), reads
// of both segment ends, multiply-accumulate and divider (one bit per cycle) before a result;
// flat segments skip the divider, clamped targets read one end entry, errors go straight out.
// Results leave one per cycle while taken; the next request is accepted after the last one.
// Reset (rst_n, asynchronous, active low) restores the registers, sets position zero and unknown.
module attenuator_calibration_stepper #(
    parameter int TABLE_DEPTH = acs_pkg::TABLE_DEPTH_DEF,
    parameter int STEP_BITS   = acs_pkg::STEP_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    acs_cmd_if.sink                          cmd,
    acs_res_if.source                        res,
    input  logic                             cfg_we,
    input  logic [acs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [acs_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import acs_pkg::*;

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int LW    = $clog2(TABLE_DEPTH + 1);
    localparam int SW    = STEP_BITS;
    localparam int SW1   = SW + 1;
    localparam int PRD_W = SW + DEN_W + 1;
    localparam int ACC_W = SW + 19;
    localparam int NUM_W = SW + 21;
    localparam int PW    = ATT_W + 11;
    localparam logic signed [32:0] STEP_MAX = (33'sd1 <<< (SW - 1)) - 33'sd1;
    localparam logic signed [32:0] STEP_MIN = -STEP_MAX - 33'sd1;
    localparam logic [SW-1:0] SAT_HI = STEP_MAX[SW-1:0];
    localparam logic [SW-1:0] SAT_LO = STEP_MIN[SW-1:0];

    state_t state_reg, state_next;

    logic [LEN_W-1:0] len_reg;
    logic [ATT_W-1:0] min_reg;
    logic [ATT_W-1:0] max_reg;

    func_t                 func_reg;
    logic [ATT_W-1:0]      a_reg;
    status_t               st_reg;
    logic [AW-1:0]         lo_reg;
    logic [AW-1:0]         hi_reg;
    logic [ATT_W-1:0]      a0_reg;
    logic [ATT_W-1:0]      a1_reg;
    logic signed [SW-1:0]  s0_reg;
    logic signed [SW-1:0]  s1_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic                  neg_reg;
    logic signed [SW-1:0]  ns_reg;
    logic signed [SW-1:0]  pos_reg;
    logic                  known_reg;
    logic                  multi_reg;

    status_t               out_status_reg;
    logic signed [MOVE_W-1:0] out_move_reg;
    logic [SPEED_W-1:0]    out_speed_reg;
    logic signed [POS_W-1:0] out_pos_reg;
    logic                  out_last_reg;

    logic                  cmd_ready;
    logic                  res_valid;
    logic                  mul_second;
    logic                  div_start;
    logic [AW-1:0]         raddr;

    logic [LW-1:0]         len_eff;
    logic [AW-1:0]         last_idx;
    logic [PW-1:0]         a_scaled;
    logic [PW-1:0]         max_scaled;
    logic [PW-1:0]         min_scaled;
    logic                  too_large;
    logic                  at_max;
    logic                  too_small;
    logic                  at_min;
    logic                  no_init;
    logic [AW-1:0]         span;
    logic                  more;
    logic [AW-1:0]         mid;

    logic                  tbl_we;
    logic signed [32:0]    es_wide;
    logic signed [SW-1:0]  es_sat;
    logic [ATT_W-1:0]      rd_att;
    logic signed [SW-1:0]  rd_step;

    logic [ATT_W-1:0]      seg_den;
    logic signed [SW:0]    mul_a;
    logic signed [DEN_W-1:0] mul_b;
    logic signed [PRD_W-1:0] mul_p;
    logic [ACC_W-1:0]      mag;
    logic [NUM_W-1:0]      div_num;
    logic [SW-1:0]         quo;
    acs_div_stat_t         div_stat;
    logic signed [SW-1:0]  q_sat;
    logic signed [SW:0]    delta;
    logic signed [SW:0]    ovs_pos;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= LEN_RESET;
            min_reg <= MIN_RESET;
            max_reg <= MAX_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TABLE_LENGTH: len_reg <= cfg_data[LEN_W-1:0];
                CFG_MIN_ATT:      min_reg <= cfg_data[ATT_W-1:0];
                CFG_MAX_ATT:      max_reg <= cfg_data[ATT_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        if (len_reg < LEN_MIN)
            len_eff = LW'(2);
        else if (int'(len_reg) > TABLE_DEPTH)
            len_eff = LW'(TABLE_DEPTH);
        else
            len_eff = LW'(len_reg);
    end

    assign last_idx   = AW'(len_eff - LW'(1));
    assign a_scaled   = PW'(a_reg) * PW'(RANGE_DEN);
    assign max_scaled = PW'(max_reg) * PW'(RANGE_HI);
    assign min_scaled = PW'(min_reg) * PW'(RANGE_LO);
    assign too_large  = a_scaled > max_scaled;
    assign at_max     = a_reg >= max_reg;
    assign too_small  = a_scaled < min_scaled;
    assign at_min     = a_reg <= min_reg;
    assign no_init    = (func_reg == FUNC_MOVE) && !known_reg;

    assign span = hi_reg - lo_reg;
    assign more = span > AW'(1);
    assign mid  = lo_reg + (span >> 1);

    // Entry steps are saturated to the step range before they are stored.
    assign es_wide = 33'(cmd.entry_step);
    always_comb
    begin
        if (es_wide > STEP_MAX)
            es_sat = SAT_HI;
        else if (es_wide < STEP_MIN)
            es_sat = SAT_LO;
        else
            es_sat = es_wide[SW-1:0];
    end

    assign tbl_we = cmd.valid && cmd_ready && (cmd.func == FUNC_LOAD)
                    && (int'(cmd.entry_index) < TABLE_DEPTH);

    acs_table #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .STEP_BITS   (STEP_BITS)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (AW'(cmd.entry_index)),
        .watt  (cmd.target_attenuation),
        .wstep (es_sat),
        .raddr (raddr),
        .ratt  (rd_att),
        .rstep (rd_step)
    );

    // Shared multiply-accumulate: step_lo * span, then plus step_delta * offset.
    assign seg_den = a1_reg - a0_reg;
    always_comb
    begin
        if (mul_second)
        begin
            mul_a = SW1'(s1_reg) - SW1'(s0_reg);
            mul_b = $signed({1'b0, a_reg}) - $signed({1'b0, a0_reg});
        end
        else
        begin
            mul_a = SW1'(s0_reg);
            mul_b = $signed({1'b0, seg_den});
        end
    end
    assign mul_p = mul_a * mul_b;

    assign mag     = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
    assign div_num = {1'b0, mag, 1'b0} + NUM_W'(seg_den);

    acs_div #(
        .STEP_BITS (STEP_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   ({seg_den, 1'b0}),
        .quo   (quo),
        .stat  (div_stat)
    );

    always_comb
    begin
        if (neg_reg)
        begin
            if (div_stat.ovf || quo > SAT_LO)
                q_sat = SAT_LO;
            else
                q_sat = SW'(-{1'b0, quo});
        end
        else
        begin
            if (div_stat.ovf || quo > SAT_HI)
                q_sat = SAT_HI;
            else
                q_sat = quo;
        end
    end

    assign delta   = SW1'(ns_reg) - SW1'(pos_reg);
    assign ovs_pos = SW1'(ns_reg) + SW1'(OVERSHOOT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid && (cmd.func == FUNC_INIT || cmd.func == FUNC_MOVE))
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                priority if (no_init || too_large)
                    state_next = S_FINISH;
                else if (at_max)
                    state_next = S_END_CAP;
                else if (too_small)
                    state_next = S_FINISH;
                else if (at_min)
                    state_next = S_END_CAP;
                else
                    state_next = S_SRCH;
            end
            S_SRCH:      state_next = more ? S_SRCH_CMP : S_RD_HI;
            S_SRCH_CMP:  state_next = S_SRCH;
            S_RD_HI:     state_next = S_CAP_HI;
            S_CAP_HI:    state_next = S_MUL_A;
            S_MUL_A:     state_next = (a1_reg <= a0_reg) ? S_FINISH : S_MUL_B;
            S_MUL_B:     state_next = S_DIV_START;
            S_DIV_START: state_next = S_DIV_WAIT;
            S_DIV_WAIT:
            begin
                if (div_stat.done)
                    state_next = S_FINISH;
            end
            S_END_CAP:   state_next = S_FINISH;
            S_FINISH:    state_next = S_OUT1;
            S_OUT1:
            begin
                if (res.ready)
                    state_next = multi_reg ? S_OUT2 : S_IDLE;
            end
            S_OUT2:
            begin
                if (res.ready)
                    state_next = S_OUT3;
            end
            S_OUT3:
            begin
                if (res.ready)
                    state_next = S_IDLE;
            end
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_ready  = 1'b0;
        res_valid  = 1'b0;
        mul_second = 1'b0;
        div_start  = 1'b0;
        raddr      = lo_reg;
        unique case (state_reg)
            S_IDLE:      cmd_ready = 1'b1;
            S_CHECK:     raddr = at_max ? last_idx : '0;
            S_SRCH:      raddr = more ? mid : lo_reg;
            S_RD_HI:     raddr = lo_reg + AW'(1);
            S_MUL_B:     mul_second = 1'b1;
            S_DIV_START: div_start = 1'b1;
            S_OUT1, S_OUT2, S_OUT3: res_valid = 1'b1;
            default:     ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            known_reg <= 1'b0;
        end
        else if (state_reg == S_FINISH && st_reg == ST_OK)
        begin
            pos_reg <= ns_reg;
            if (func_reg == FUNC_INIT)
                known_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                func_reg <= func_t'(cmd.func);
                a_reg    <= cmd.target_attenuation;
            end
            S_CHECK:
            begin
                lo_reg <= '0;
                hi_reg <= last_idx;
                priority if (no_init)
                    st_reg <= ST_NO_INIT;
                else if (too_large)
                    st_reg <= ST_TOO_LARGE;
                else if (at_max)
                    st_reg <= ST_OK;
                else if (too_small)
                    st_reg <= ST_TOO_SMALL;
                else
                    st_reg <= ST_OK;
            end
            S_SRCH_CMP:
            begin
                if (a_reg < rd_att)
                    hi_reg <= mid;
                else
                    lo_reg <= mid;
            end
            S_RD_HI:
            begin
                a0_reg <= rd_att;
                s0_reg <= rd_step;
            end
            S_CAP_HI:
            begin
                a1_reg <= rd_att;
                s1_reg <= rd_step;
            end
            S_MUL_A:
            begin
                acc_reg <= ACC_W'(mul_p);
                ns_reg  <= s0_reg;
            end
            S_MUL_B:     acc_reg <= acc_reg + ACC_W'(mul_p);
            S_DIV_START: neg_reg <= acc_reg[ACC_W-1];
            S_DIV_WAIT:  ns_reg  <= q_sat;
            S_END_CAP:   ns_reg  <= rd_step;
            S_FINISH:
            begin
                out_status_reg <= st_reg;
                out_move_reg   <= '0;
                out_speed_reg  <= NO_SPEED;
                out_last_reg   <= 1'b1;
                multi_reg      <= 1'b0;
                if (st_reg != ST_OK)
                begin
                    out_pos_reg <= POS_W'(pos_reg);
                end
                else
                begin
                    out_pos_reg <= POS_W'(ns_reg);
                    if (func_reg == FUNC_MOVE && delta != '0)
                    begin
                        out_move_reg  <= MOVE_W'(delta);
                        out_speed_reg <= FAST_SPEED;
                        if (!delta[SW])
                        begin
                            out_last_reg <= 1'b0;
                            multi_reg    <= 1'b1;
                        end
                    end
                end
            end
            S_OUT1:
            begin
                if (res.ready && multi_reg)
                begin
                    out_move_reg  <= MOVE_W'(OVERSHOOT);
                    out_speed_reg <= SLOW_SPEED;
                    out_pos_reg   <= POS_W'(ovs_pos);
                    out_last_reg  <= 1'b0;
                end
            end
            S_OUT2:
            begin
                if (res.ready)
                begin
                    out_move_reg  <= MOVE_W'(-OVERSHOOT);
                    out_speed_reg <= FAST_SPEED;
                    out_pos_reg   <= POS_W'(ns_reg);
                    out_last_reg  <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign cmd.ready      = cmd_ready;
    assign res.valid      = res_valid;
    assign res.status     = out_status_reg;
    assign res.move_steps = out_move_reg;
    assign res.move_speed = out_speed_reg;
    assign res.position   = out_pos_reg;
    assign res.last       = out_last_reg;

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.ready && res.valid))
        else $error("request taken while a result is pending");

    a_known_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        known_reg |=> known_reg)
        else $error("position lost its known flag");

    a_slow_is_overshoot: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.move_speed == SLOW_SPEED |-> res.move_steps == MOVE_W'(OVERSHOOT))
        else $error("slow move is not the overshoot");

    a_error_no_move: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.status != ST_OK |-> res.move_steps == '0 && res.move_speed == NO_SPEED)
        else $error("error result carries a move");

    a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> state_reg == S_DIV_WAIT)
        else $error("divider finished outside its wait state");

endmodule

// File: verif/attenuator_calibration_stepper_chk.sv
`timescale 1ns / 1ps

module attenuator_calibration_stepper_chk
    import acs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    acs_cmd_if                    cmd,
    acs_res_if                    res,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    errors,
    output int                    pending
);

    typedef struct packed {
        status_t                  status;
        logic signed [MOVE_W-1:0] move_steps;
        logic [SPEED_W-1:0]       move_speed;
        logic signed [POS_W-1:0]  position;
        logic                     last;
    } motor_cmd_t;

    localparam longint STEP_MAX = (longint'(1) << (STEP_BITS_DEF - 1)) - 1;
    localparam longint STEP_MIN = -STEP_MAX - 1;

    logic [ATT_W-1:0] cal_att [TABLE_DEPTH_DEF];
    longint           cal_step [TABLE_DEPTH_DEF];
    logic [LEN_W-1:0] len_reg;
    logic [ATT_W-1:0] min_reg;
    logic [ATT_W-1:0] max_reg;
    longint           pos_now;
    bit               pos_valid;
    motor_cmd_t       motor_cmds[$];

    function automatic motor_cmd_t make_cmd(status_t st, longint mv,
                                            logic [SPEED_W-1:0] spd, longint pos,
                                            logic fin);
        motor_cmd_t c;
        c.status     = st;
        c.move_steps = mv[MOVE_W-1:0];
        c.move_speed = spd;
        c.position   = pos[POS_W-1:0];
        c.last       = fin;
        return c;
    endfunction

    // Range check, segment search and rounded interpolation of one target.
    function automatic status_t target_to_step(input logic [ATT_W-1:0] target,
                                               output longint stp);
        int unsigned n;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        longint      av;
        longint      a0;
        longint      a1;
        longint      s0;
        longint      s1;
        longint      den;
        longint      t;
        longint      mag;
        longint      q;
        n = len_reg;
        if (n < 2)
        begin
            n = 2;
        end
        if (n > TABLE_DEPTH_DEF)
        begin
            n = TABLE_DEPTH_DEF;
        end
        av = target;
        if (av * 1000 > longint'(max_reg) * 1001)
        begin
            return ST_TOO_LARGE;
        end
        if (av >= longint'(max_reg))
        begin
            stp = cal_step[n - 1];
            return ST_OK;
        end
        if (av * 1000 < longint'(min_reg) * 999)
        begin
            return ST_TOO_SMALL;
        end
        if (av <= longint'(min_reg))
        begin
            stp = cal_step[0];
            return ST_OK;
        end
        lo = 0;
        hi = n - 1;
        while (hi - lo > 1)
        begin
            mid = lo + (hi - lo) / 2;
            if (av < longint'(cal_att[mid]))
            begin
                hi = mid;
            end
            else
            begin
                lo = mid;
            end
        end
        a0 = cal_att[lo];
        a1 = cal_att[lo + 1];
        s0 = cal_step[lo];
        s1 = cal_step[lo + 1];
        if (a1 <= a0)
        begin
            stp = s0;
            return ST_OK;
        end
        den = a1 - a0;
        t   = s0 * den + (s1 - s0) * (av - a0);
        mag = (t < 0) ? -t : t;
        q   = (2 * mag + den) / (2 * den);
        if (t < 0)
        begin
            q = -q;
        end
        if (q > STEP_MAX)
        begin
            q = STEP_MAX;
        end
        else if (q < STEP_MIN)
        begin
            q = STEP_MIN;
        end
        stp = q;
        return ST_OK;
    endfunction

    always @(posedge clk)
    begin : watch
        motor_cmd_t want;
        motor_cmd_t got;
        status_t    st;
        longint     ns;
        longint     delta;
        if (!rst_n)
        begin
            len_reg   = LEN_RESET;
            min_reg   = MIN_RESET;
            max_reg   = MAX_RESET;
            pos_now   = 0;
            pos_valid = 1'b0;
            errors    = 0;
            motor_cmds.delete();
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                got = make_cmd(status_t'(res.status), res.move_steps, res.move_speed,
                               res.position, res.last);
                if (motor_cmds.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                    begin
                        $display("unexpected result: status %0d move %0d speed %0d pos %0d last %0d",
                                 got.status, $signed(got.move_steps), got.move_speed,
                                 $signed(got.position), got.last);
                    end
                end
                else
                begin
                    want = motor_cmds.pop_front();
                    if (got.status !== want.status || got.move_steps !== want.move_steps ||
                        got.move_speed !== want.move_speed ||
                        got.position !== want.position || got.last !== want.last)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("result mismatch: expected status %0d move %0d speed %0d pos %0d last %0d",
                                     want.status, $signed(want.move_steps), want.move_speed,
                                     $signed(want.position), want.last);
                            $display("                 actual   status %0d move %0d speed %0d pos %0d last %0d",
                                     got.status, $signed(got.move_steps), got.move_speed,
                                     $signed(got.position), got.last);
                        end
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TABLE_LENGTH: len_reg = cfg_data[LEN_W-1:0];
                    CFG_MIN_ATT:      min_reg = cfg_data[ATT_W-1:0];
                    CFG_MAX_ATT:      max_reg = cfg_data[ATT_W-1:0];
                    default:          ;
                endcase
            end
            if (cmd.valid && cmd.ready)
            begin
                case (cmd.func)
                    FUNC_LOAD:
                    begin
                        cal_att[cmd.entry_index]  = cmd.target_attenuation;
                        cal_step[cmd.entry_index] = longint'(cmd.entry_step);
                    end
                    FUNC_INIT:
                    begin
                        st = target_to_step(cmd.target_attenuation, ns);
                        if (st == ST_OK)
                        begin
                            pos_now   = ns;
                            pos_valid = 1'b1;
                        end
                        motor_cmds.push_back(make_cmd(st, 0, NO_SPEED, pos_now, 1'b1));
                    end
                    FUNC_MOVE:
                    begin
                        if (!pos_valid)
                        begin
                            motor_cmds.push_back(make_cmd(ST_NO_INIT, 0, NO_SPEED, pos_now, 1'b1));
                        end
                        else
                        begin
                            st = target_to_step(cmd.target_attenuation, ns);
                            if (st != ST_OK)
                            begin
                                motor_cmds.push_back(make_cmd(st, 0, NO_SPEED, pos_now, 1'b1));
                            end
                            else
                            begin
                                delta   = ns - pos_now;
                                pos_now = ns;
                                if (delta == 0)
                                begin
                                    motor_cmds.push_back(make_cmd(ST_OK, 0, NO_SPEED, ns, 1'b1));
                                end
                                else if (delta < 0)
                                begin
                                    motor_cmds.push_back(make_cmd(ST_OK, delta, FAST_SPEED, ns,
                                                                  1'b1));
                                end
                                else
                                begin
                                    motor_cmds.push_back(make_cmd(ST_OK, delta, FAST_SPEED, ns,
                                                                  1'b0));
                                    motor_cmds.push_back(make_cmd(ST_OK, OVERSHOOT, SLOW_SPEED,
                                                                  ns + OVERSHOOT, 1'b0));
                                    motor_cmds.push_back(make_cmd(ST_OK, -OVERSHOOT, FAST_SPEED,
                                                                  ns, 1'b1));
                                end
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
        pending = motor_cmds.size();
    end

endmodule

// File: verif/attenuator_calibration_stepper_tb.sv
`timescale 1ns / 1ps

module attenuator_calibration_stepper_tb;
    import acs_pkg::*;

    localparam int HALF_PERIOD       = 6;
    localparam int RESET_CYCLES      = 8;
    localparam int SETTLE_CYCLES     = 64;
    localparam int CYCLE_LIMIT       = 400000;
    localparam int REQUEST_COUNT     = 500;
    localparam int HOLD_AT           = 290;
    localparam int HOLD_CYCLES       = 400;
    localparam int QUIET_FROM        = 360;
    localparam int QUIET_TO          = 460;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0]              func;
        logic [IDX_W-1:0]               entry_index;
        logic [ATT_W-1:0]               att;
        logic signed [ENTRY_STEP_W-1:0] entry_step;
    } stepper_request_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    int                    errors;
    int                    pending;
    int                    requests_accepted = 0;
    int                    requests_queued = 0;
    int                    hold_left = 0;
    bit                    hold_done = 1'b0;
    logic                  quiet;
    stepper_request_t      request_fifo[$];

    acs_cmd_if cmd ();
    acs_res_if res ();

    attenuator_calibration_stepper u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    attenuator_calibration_stepper_chk u_chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    assign quiet = (requests_accepted >= QUIET_FROM) && (requests_accepted < QUIET_TO);

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    always @(posedge clk)
    begin : drive_requests
        stepper_request_t req;
        if (!rst_n)
        begin
            cmd.valid <= 1'b0;
        end
        else
        begin
            if (cmd.valid && cmd.ready)
            begin
                requests_accepted <= requests_accepted + 1;
            end
            if (!cmd.valid || cmd.ready)
            begin
                if (request_fifo.size() != 0 && (quiet || $urandom_range(99) >= 10))
                begin
                    req = request_fifo.pop_front();
                    cmd.valid              <= 1'b1;
                    cmd.func               <= req.func;
                    cmd.entry_index        <= req.entry_index;
                    cmd.target_attenuation <= req.att;
                    cmd.entry_step         <= req.entry_step;
                end
                else
                begin
                    cmd.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            res.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            res.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && requests_accepted >= HOLD_AT)
        begin
            res.ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else
        begin
            res.ready <= quiet || ($urandom_range(99) >= 10);
        end
    end

    initial
    begin : watchdog
        int cycle;
        for (cycle = 0; cycle < CYCLE_LIMIT; cycle++)
        begin
            @(posedge clk);
        end
        $display("** attenuator_calibration_stepper: FAILED **");
        $finish;
    end

    task automatic queue_request(logic [FUNC_W-1:0] func, int idx, int att, int step);
        stepper_request_t r;
        r.func        = func;
        r.entry_index = idx[IDX_W-1:0];
        r.att         = att[ATT_W-1:0];
        r.entry_step  = step[ENTRY_STEP_W-1:0];
        request_fifo.push_back(r);
        requests_queued++;
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (request_fifo.size() != 0 || cmd.valid || pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data[CFG_DATA_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Register setting, sorted table loads, then mostly init and move requests.
    task automatic run_phase(int phase);
        int att_tab [TABLE_DEPTH_DEF];
        int step_tab [TABLE_DEPTH_DEF];
        int raw_len;
        int n;
        int loads;
        int ops;
        int r;
        int i;
        int maxinc;
        int dir;
        int lo_reg;
        int hi_reg;
        int target;
        logic signed [ENTRY_STEP_W-1:0] s24;
        if (phase == 0)
        begin
            raw_len = TABLE_DEPTH_DEF;
        end
        else if (phase == 3)
        begin
            raw_len = 511;
        end
        else
        begin
            r = $urandom_range(99);
            if (r < 4)
            begin
                raw_len = $urandom_range(1, 0);
            end
            else if (r < 10)
            begin
                raw_len = $urandom_range(511, 257);
            end
            else if (r < 20)
            begin
                raw_len = $urandom_range(64, 13);
            end
            else
            begin
                raw_len = $urandom_range(12, 2);
            end
        end
        n = (raw_len < 2) ? 2 : ((raw_len > TABLE_DEPTH_DEF) ? TABLE_DEPTH_DEF : raw_len);
        loads = (phase == 0 || n <= 64) ? n : 32;

        att_tab[0] = (phase == 0) ? 0 : $urandom_range(40000, 0);
        maxinc = (65535 - att_tab[0]) / (n - 1);
        if (phase != 0 && maxinc > 1)
        begin
            maxinc = $urandom_range(maxinc, 1);
        end
        for (i = 1; i < n; i++)
        begin
            att_tab[i] = att_tab[i - 1] + ((phase == 0) ? maxinc : $urandom_range(maxinc, 0));
        end

        r = $urandom_range(99);
        dir = $urandom_range(1) ? 1 : -1;
        step_tab[0] = $urandom_range(2000000, 0) - 1000000;
        for (i = 0; i < n; i++)
        begin
            if (r < 30)
            begin
                s24 = $urandom();
                step_tab[i] = s24;
            end
            else if (i > 0)
            begin
                step_tab[i] = step_tab[i - 1] + dir * $urandom_range(25000, 0);
            end
        end

        if ($urandom_range(99) < 10)
        begin
            lo_reg = $urandom_range(65535, 0);
            hi_reg = $urandom_range(65535, lo_reg);
        end
        else
        begin
            lo_reg = att_tab[0];
            hi_reg = att_tab[n - 1];
        end
        write_reg(CFG_TABLE_LENGTH, raw_len);
        write_reg(CFG_MIN_ATT, lo_reg);
        write_reg(CFG_MAX_ATT, hi_reg);

        for (i = 0; i < loads; i++)
        begin
            queue_request(FUNC_LOAD, i, att_tab[i], step_tab[i]);
        end

        ops = $urandom_range(40, 20);
        for (i = 0; i < ops; i++)
        begin
            r = $urandom_range(99);
            if (r < 70)
            begin
                target = $urandom_range(hi_reg, lo_reg);
            end
            else if (r < 80)
            begin
                target = att_tab[$urandom_range(n - 1, 0)];
            end
            else if (r < 90)
            begin
                if ($urandom_range(1))
                begin
                    target = hi_reg + $urandom_range(hi_reg / 1000 + 2, 0);
                end
                else
                begin
                    target = lo_reg - $urandom_range(lo_reg / 1000 + 2, 0);
                end
            end
            else
            begin
                target = $urandom_range(65535, 0);
            end
            target = (target > 65535) ? 65535 : ((target < 0) ? 0 : target);

            r = $urandom_range(99);
            if (r < 4)
            begin
                queue_request(FUNC_UNUSED, $urandom_range(255, 0), $urandom_range(65535, 0),
                              $urandom());
            end
            else if (r < 8)
            begin
                queue_request(FUNC_LOAD, $urandom_range(255, 0), $urandom_range(65535, 0),
                              $urandom());
            end
            else if (r < 25)
            begin
                queue_request(FUNC_INIT, 0, target, 0);
            end
            else
            begin
                queue_request(FUNC_MOVE, $urandom_range(255, 0), target, $urandom());
            end
        end
    endtask

    initial
    begin : stimulus
        int phase;
        cmd.valid              = 1'b0;
        cmd.func               = FUNC_LOAD;
        cmd.entry_index        = '0;
        cmd.target_attenuation = '0;
        cmd.entry_step         = '0;
        res.ready              = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Registers still at their reset values: full-range two-entry table.
        queue_request(FUNC_MOVE, 0, 1234, 0);
        queue_request(FUNC_UNUSED, 255, 65535, -1);
        queue_request(FUNC_LOAD, 0, 0, -8388608);
        queue_request(FUNC_LOAD, 1, 65535, 8388607);
        queue_request(FUNC_LOAD, 255, 65535, 0);
        queue_request(FUNC_INIT, 0, 0, 0);
        queue_request(FUNC_MOVE, 0, 65535, 0);
        queue_request(FUNC_MOVE, 0, 32768, 0);
        queue_request(FUNC_MOVE, 0, 32768, 0);

        // Tolerance edges, rounding of halves both ways and a flat segment.
        wait_idle();
        write_reg(CFG_MIN_ATT, 10000);
        write_reg(CFG_MAX_ATT, 20000);
        queue_request(FUNC_LOAD, 0, 10000, 100);
        queue_request(FUNC_LOAD, 1, 20000, 1100);
        queue_request(FUNC_MOVE, 0, 20020, 0);
        queue_request(FUNC_MOVE, 0, 20021, 0);
        queue_request(FUNC_INIT, 0, 9989, 0);
        queue_request(FUNC_INIT, 0, 9990, 0);
        queue_request(FUNC_MOVE, 0, 15005, 0);
        queue_request(FUNC_LOAD, 0, 10000, -100);
        queue_request(FUNC_LOAD, 1, 20000, -1100);
        queue_request(FUNC_MOVE, 0, 15005, 0);
        queue_request(FUNC_LOAD, 1, 10000, 5);
        queue_request(FUNC_MOVE, 0, 15000, 0);

        // Registers wider than the table: extrapolation and saturation.
        wait_idle();
        write_reg(CFG_MIN_ATT, 0);
        write_reg(CFG_MAX_ATT, 65535);
        queue_request(FUNC_LOAD, 0, 10000, 8000000);
        queue_request(FUNC_LOAD, 1, 20000, 8388607);
        queue_request(FUNC_MOVE, 0, 60000, 0);
        queue_request(FUNC_MOVE, 0, 100, 0);

        phase = 0;
        while (requests_queued < REQUEST_COUNT)
        begin
            wait_idle();
            run_phase(phase);
            phase++;
        end
        wait_idle();

        if (errors == 0)
        begin
            $display("** attenuator_calibration_stepper: PASSED **");
        end
        else
        begin
            $display("** attenuator_calibration_stepper: FAILED **");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/acs_pkg.sv
rtl/acs_if.sv
rtl/acs_table.sv
rtl/acs_div.sv
rtl/attenuator_calibration_stepper.sv
verif/attenuator_calibration_stepper_chk.sv
verif/attenuator_calibration_stepper_tb.sv
